>>> hw/rtl/avr_pkg.sv
package avr_pkg;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
        logic        [15:0] turn_angle;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } out_t;

    localparam int CORDIC_STAGES = 16;
    localparam logic signed [26:0] CORDIC_X0 = 27'sd10188014;
    localparam logic signed [24:0] HALF_TURN = 25'sd8388608;
    localparam logic signed [24:0] QUARTER_TURN = 25'sd4194304;
    localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

    localparam logic signed [24:0] ATAN_TAB [0:CORDIC_STAGES-1] = '{
        25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050,
        25'sd166669, 25'sd83416, 25'sd41718, 25'sd20860,
        25'sd10430, 25'sd5215, 25'sd2608, 25'sd1304,
        25'sd652, 25'sd326, 25'sd163, 25'sd81
    };

endpackage

>>> hw/rtl/axis_angle_vector_rotate.sv
// Channel  Transfer when     Payload
// input    start && !busy    item   (axis, vector, turn_angle)
// output   done              result (out_x, out_y, out_z)
//
// One item per cycle; the 16-stage CORDIC with its fold and rounding
// registers feeds the matrix forming and application stages.
// busy stays low: the pipeline never stalls since the receiver cannot.
// Reset clears only the valid bits; no state is kept between items.
module axis_angle_vector_rotate (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  avr_pkg::in_t   item,
    output logic           done,
    output avr_pkg::out_t  result
);

    logic               cs_valid;
    avr_pkg::in_t       cs_item;
    logic signed [16:0] cos_q14;
    logic signed [16:0] sin_q14;

    assign busy = 1'b0;

    avr_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_item   (item),
        .out_valid (cs_valid),
        .out_item  (cs_item),
        .cos_q14   (cos_q14),
        .sin_q14   (sin_q14)
    );

    avr_matrix u_matrix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cs_valid),
        .in_item    (cs_item),
        .cos_q14    (cos_q14),
        .sin_q14    (sin_q14),
        .out_valid  (done),
        .out_result (result)
    );

endmodule

>>> hw/rtl/avr_cordic.sv
module avr_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  avr_pkg::in_t        in_item,
    output logic                out_valid,
    output avr_pkg::in_t        out_item,
    output logic signed [16:0]  cos_q14,
    output logic signed [16:0]  sin_q14
);

    localparam int N = avr_pkg::CORDIC_STAGES;

    logic signed [26:0] x_reg [0:N];
    logic signed [26:0] y_reg [0:N];
    logic signed [24:0] z_reg [0:N];
    logic               neg_reg [0:N];
    logic               vld_reg [0:N];
    avr_pkg::in_t       item_reg [0:N];

    logic signed [24:0] z_raw;
    logic signed [24:0] z_fold;
    logic               neg_fold;

    logic               vld_out_reg;
    avr_pkg::in_t       item_out_reg;
    logic signed [16:0] cos_reg;
    logic signed [16:0] sin_reg;

    logic signed [26:0] x_rnd;
    logic signed [26:0] y_rnd;
    logic signed [16:0] c_rnd;
    logic signed [16:0] s_rnd;

    // fold into +/- quarter turn, result negated afterwards
    always_comb
    begin
        z_raw = 25'(signed'({in_item.turn_angle, 8'b0}));
        z_fold = z_raw;
        neg_fold = 1'b0;
        if (z_raw > avr_pkg::QUARTER_TURN)
        begin
            z_fold = z_raw - avr_pkg::HALF_TURN;
            neg_fold = 1'b1;
        end
        else if (z_raw < -avr_pkg::QUARTER_TURN)
        begin
            z_fold = z_raw + avr_pkg::HALF_TURN;
            neg_fold = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= N; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            vld_out_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= avr_pkg::CORDIC_X0;
        y_reg[0] <= '0;
        z_reg[0] <= z_fold;
        neg_reg[0] <= neg_fold;
        item_reg[0] <= in_item;
    end

    for (genvar i = 1; i <= N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (z_reg[i-1] >= 0)
            begin
                x_reg[i] <= x_reg[i-1] - (y_reg[i-1] >>> (i - 1));
                y_reg[i] <= y_reg[i-1] + (x_reg[i-1] >>> (i - 1));
                z_reg[i] <= z_reg[i-1] - avr_pkg::ATAN_TAB[i-1];
            end
            else
            begin
                x_reg[i] <= x_reg[i-1] + (y_reg[i-1] >>> (i - 1));
                y_reg[i] <= y_reg[i-1] - (x_reg[i-1] >>> (i - 1));
                z_reg[i] <= z_reg[i-1] + avr_pkg::ATAN_TAB[i-1];
            end
            neg_reg[i] <= neg_reg[i-1];
            item_reg[i] <= item_reg[i-1];
        end
    end

    always_comb
    begin
        x_rnd = (x_reg[N] + 27'sd512) >>> 10;
        y_rnd = (y_reg[N] + 27'sd512) >>> 10;
        c_rnd = x_rnd[16:0];
        s_rnd = y_rnd[16:0];
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= neg_reg[N] ? -c_rnd : c_rnd;
        sin_reg <= neg_reg[N] ? -s_rnd : s_rnd;
        item_out_reg <= item_reg[N];
    end

    assign out_valid = vld_out_reg;
    assign out_item = item_out_reg;
    assign cos_q14 = cos_reg;
    assign sin_q14 = sin_reg;

endmodule

>>> hw/rtl/avr_matrix.sv
module avr_matrix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  avr_pkg::in_t        in_item,
    input  logic signed [16:0]  cos_q14,
    input  logic signed [16:0]  sin_q14,
    output logic                out_valid,
    output avr_pkg::out_t       out_result
);

    logic [4:0] vld_reg;

    // stage 1: t*a and s*a
    logic signed [33:0] tx_reg, ty_reg, tz_reg;
    logic signed [32:0] sx1_reg, sy1_reg, sz1_reg;
    logic signed [16:0] c1_reg;
    avr_pkg::in_t       it1_reg;
    logic signed [17:0] t_val;

    // stage 2: t*a*b
    logic signed [49:0] txx_reg, txy_reg, txz_reg, tyy_reg, tyz_reg, tzz_reg;
    logic signed [32:0] sx2_reg, sy2_reg, sz2_reg;
    logic signed [16:0] c2_reg;
    avr_pkg::in_t       it2_reg;

    // stage 3: matrix entries, Q.28
    logic signed [34:0] m_reg [0:8];
    logic signed [47:0] m_sum [0:8];
    logic signed [47:0] m_rnd [0:8];
    logic signed [47:0] cs, sx_s, sy_s, sz_s;
    logic signed [15:0] vx3_reg, vy3_reg, vz3_reg;

    // stage 4: entry times vector component
    logic signed [50:0] p_reg [0:8];

    // stage 5: row sums, rounded and clamped
    logic signed [53:0] r_sum [0:2];
    logic signed [53:0] r_rnd [0:2];
    logic signed [15:0] r_sat [0:2];
    avr_pkg::out_t      res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign t_val = avr_pkg::ONE_Q14 - 18'(cos_q14);

    always_ff @(posedge clk)
    begin
        tx_reg <= t_val * in_item.axis_x;
        ty_reg <= t_val * in_item.axis_y;
        tz_reg <= t_val * in_item.axis_z;
        sx1_reg <= sin_q14 * in_item.axis_x;
        sy1_reg <= sin_q14 * in_item.axis_y;
        sz1_reg <= sin_q14 * in_item.axis_z;
        c1_reg <= cos_q14;
        it1_reg <= in_item;
    end

    always_ff @(posedge clk)
    begin
        txx_reg <= tx_reg * it1_reg.axis_x;
        txy_reg <= tx_reg * it1_reg.axis_y;
        txz_reg <= tx_reg * it1_reg.axis_z;
        tyy_reg <= ty_reg * it1_reg.axis_y;
        tyz_reg <= ty_reg * it1_reg.axis_z;
        tzz_reg <= tz_reg * it1_reg.axis_z;
        sx2_reg <= sx1_reg;
        sy2_reg <= sy1_reg;
        sz2_reg <= sz1_reg;
        c2_reg <= c1_reg;
        it2_reg <= it1_reg;
    end

    always_comb
    begin
        cs = 48'(c2_reg) <<< 28;
        sx_s = 48'(sx2_reg) <<< 14;
        sy_s = 48'(sy2_reg) <<< 14;
        sz_s = 48'(sz2_reg) <<< 14;
        m_sum[0] = cs + 48'(txx_reg);
        m_sum[1] = 48'(txy_reg) - sz_s;
        m_sum[2] = 48'(txz_reg) + sy_s;
        m_sum[3] = 48'(txy_reg) + sz_s;
        m_sum[4] = cs + 48'(tyy_reg);
        m_sum[5] = 48'(tyz_reg) - sx_s;
        m_sum[6] = 48'(txz_reg) - sy_s;
        m_sum[7] = 48'(tyz_reg) + sx_s;
        m_sum[8] = cs + 48'(tzz_reg);
        for (int k = 0; k < 9; k++)
        begin
            m_rnd[k] = (m_sum[k] + 48'sd8192) >>> 14;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            m_reg[k] <= m_rnd[k][34:0];
        end
        vx3_reg <= it2_reg.vec_x;
        vy3_reg <= it2_reg.vec_y;
        vz3_reg <= it2_reg.vec_z;
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            p_reg[3*r]   <= m_reg[3*r]   * vx3_reg;
            p_reg[3*r+1] <= m_reg[3*r+1] * vy3_reg;
            p_reg[3*r+2] <= m_reg[3*r+2] * vz3_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            r_sum[r] = 54'(p_reg[3*r]) + 54'(p_reg[3*r+1]) + 54'(p_reg[3*r+2]);
            r_rnd[r] = (r_sum[r] + 54'sd134217728) >>> 28;
            if (r_rnd[r] > 54'sd32767)
            begin
                r_sat[r] = 16'sd32767;
            end
            else if (r_rnd[r] < -54'sd32768)
            begin
                r_sat[r] = -16'sd32768;
            end
            else
            begin
                r_sat[r] = r_rnd[r][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg.out_x <= r_sat[0];
        res_reg.out_y <= r_sat[1];
        res_reg.out_z <= r_sat[2];
    end

    assign out_valid = vld_reg[4];
    assign out_result = res_reg;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY   = 23;
    localparam int N_RANDOM  = 1400;
    localparam int IDLE_LIMIT = 2000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    avr_pkg::in_t   item;
    logic           done;
    avr_pkg::out_t  result;

    axis_angle_vector_rotate dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    avr_pkg::in_t  pending_items[$];
    avr_pkg::out_t rotated_expected[$];
    int   errors;
    int   accepted;
    int   checked;
    int   idle_cycles;
    bit   calm;
    bit   hold_off;

    // CORDIC cos/sin in Q.14 with quarter-turn fold
    function automatic void cordic_cos_sin(input logic [15:0] ang,
                                           output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     neg;
        z = longint'(ang) <<< 8;
        x = avr_pkg::CORDIC_X0;
        y = 0;
        neg = 0;
        if (z >= avr_pkg::HALF_TURN)
            z -= 64'sd16777216;
        if (z > avr_pkg::QUARTER_TURN)
        begin
            z -= avr_pkg::HALF_TURN;
            neg = 1;
        end
        else if (z < -avr_pkg::QUARTER_TURN)
        begin
            z += avr_pkg::HALF_TURN;
            neg = 1;
        end
        for (int i = 0; i < avr_pkg::CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= avr_pkg::ATAN_TAB[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += avr_pkg::ATAN_TAB[i];
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
        if (neg)
        begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic longint rnd(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic avr_pkg::out_t rotate_vector(input avr_pkg::in_t it);
        longint ax, ay, az, vx, vy, vz;
        longint c, s, t, cs, sx, sy, sz;
        longint m[3][3];
        avr_pkg::out_t r;
        ax = it.axis_x;
        ay = it.axis_y;
        az = it.axis_z;
        vx = it.vec_x;
        vy = it.vec_y;
        vz = it.vec_z;
        cordic_cos_sin(it.turn_angle, c, s);
        t  = avr_pkg::ONE_Q14 - c;
        cs = c <<< 28;
        sx = (ax * s) <<< 14;
        sy = (ay * s) <<< 14;
        sz = (az * s) <<< 14;
        m[0][0] = rnd(cs + t * ax * ax, 14);
        m[0][1] = rnd(t * ax * ay - sz, 14);
        m[0][2] = rnd(t * ax * az + sy, 14);
        m[1][0] = rnd(t * ax * ay + sz, 14);
        m[1][1] = rnd(cs + t * ay * ay, 14);
        m[1][2] = rnd(t * ay * az - sx, 14);
        m[2][0] = rnd(t * ax * az - sy, 14);
        m[2][1] = rnd(t * ay * az + sx, 14);
        m[2][2] = rnd(cs + t * az * az, 14);
        r.out_x = clamp16(rnd(m[0][0] * vx + m[0][1] * vy + m[0][2] * vz, 28));
        r.out_y = clamp16(rnd(m[1][0] * vx + m[1][1] * vy + m[1][2] * vz, 28));
        r.out_z = clamp16(rnd(m[2][0] * vx + m[2][1] * vy + m[2][2] * vz, 28));
        return r;
    endfunction

    function automatic avr_pkg::in_t make_item(input logic [15:0] ax, input logic [15:0] ay,
                                               input logic [15:0] az, input logic [15:0] vx,
                                               input logic [15:0] vy, input logic [15:0] vz,
                                               input logic [15:0] ang);
        avr_pkg::in_t it;
        it.axis_x = ax;
        it.axis_y = ay;
        it.axis_z = az;
        it.vec_x = vx;
        it.vec_y = vy;
        it.vec_z = vz;
        it.turn_angle = ang;
        return it;
    endfunction

    function automatic logic [15:0] rand_q14();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 16'hFFFF));
            1: return 16'($urandom_range(0, 32768) - 16384);
            default: return 16'($urandom_range(0, 16384) - 8192);
        endcase
    endfunction

    // axis: a signed unit along one direction, a three-way diagonal, or random values
    function automatic avr_pkg::in_t rand_item();
        avr_pkg::in_t it;
        int  shape;
        shape = $urandom_range(0, 9);
        it = make_item(rand_q14(), rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                       rand_q14(), 16'($urandom_range(0, 16'hFFFF)));
        if (shape < 6)
        begin
            it.axis_x = 0;
            it.axis_y = 0;
            it.axis_z = 0;
            case ($urandom_range(0, 2))
                0: it.axis_x = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                1: it.axis_y = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                default: it.axis_z = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            endcase
        end
        else if (shape == 6)
        begin
            it.axis_x = 16'sd9459;
            it.axis_y = 16'sd9459;
            it.axis_z = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
        end
        return it;
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            if (start && !busy)
                void'(pending_items.pop_front());
            if (!hold_off && pending_items.size() > 0
                && (calm || $urandom_range(0, 99) >= 7))
            begin
                start <= 1'b1;
                item  <= pending_items[0];
            end
            else
            begin
                start <= 1'b0;
                item  <= make_item(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            end
        end
    end

    // input transfer and result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
            begin
                rotated_expected.push_back(rotate_vector(item));
                accepted <= accepted + 1;
            end
            if (done)
            begin
                if (rotated_expected.size() == 0)
                begin
                    $error("unexpected result %h", result);
                    errors++;
                end
                else
                begin
                    avr_pkg::out_t e;
                    e = rotated_expected.pop_front();
                    checked <= checked + 1;
                    if (result.out_x !== e.out_x)
                    begin
                        $error("out_x expected %0d got %0d", e.out_x, result.out_x);
                        errors++;
                    end
                    if (result.out_y !== e.out_y)
                    begin
                        $error("out_y expected %0d got %0d", e.out_y, result.out_y);
                        errors++;
                    end
                    if (result.out_z !== e.out_z)
                    begin
                        $error("out_z expected %0d got %0d", e.out_z, result.out_z);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer in %0d cycles", IDLE_LIMIT);
            $display("[axis_angle_vector_rotate] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] extremes [4];
        errors = 0;
        accepted = 0;
        checked = 0;
        idle_cycles = 0;
        calm = 0;
        hold_off = 0;
        rst_n = 1'b0;
        extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

        // directed: angle corners, axis cases, saturation, zero axis
        pending_items.push_back(make_item(0, 0, 16384, 16384, 0, 0, 0));
        pending_items.push_back(make_item(0, 0, 16384, 16384, 0, 0, 16'h4000));
        pending_items.push_back(make_item(0, 0, 16384, 16384, 0, 0, 16'h8000));
        pending_items.push_back(make_item(0, 0, 16384, 16384, 0, 0, 16'hC000));
        pending_items.push_back(make_item(0, 0, 16384, 16384, 0, 0, 16'hFFFF));
        pending_items.push_back(make_item(0, 0, 16384, 16384, 0, 0, 16'h4001));
        pending_items.push_back(make_item(0, 0, 16384, 16384, 0, 0, 16'hBFFF));
        pending_items.push_back(make_item(16384, 0, 0, 0, 16384, 16384, 16'h2000));
        pending_items.push_back(make_item(0, 16384, 0, 16384, 16384, 16384, 16'h6000));
        pending_items.push_back(make_item(0, 0, 0, 16'h7FFF, 16'h8000, 12345, 16'h1234));
        pending_items.push_back(make_item(0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(extremes[i], extremes[(i + 1) % 4],
                extremes[(i + 2) % 4], extremes[i], extremes[(i + 3) % 4],
                extremes[(i + 1) % 4], i[1] ? 16'hFFFF : 16'h0001));
        pending_items.push_back(make_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                          16'h7FFF, 16'h7FFF, 16'h2000));
        pending_items.push_back(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                          16'h8000, 16'h8000, 16'h7FFF));
        pending_items.push_back(make_item(9459, 9459, 9459, 16384, 0, 0, 16'h5555));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            calm = (phase == 2);
            for (int i = 0; i < N_RANDOM / 4; i++)
                pending_items.push_back(rand_item());
            wait (pending_items.size() == 0);
            if (phase == 1)
            begin
                // hold off until the pipeline has drained
                @(negedge clk);
                hold_off = 1;
                wait (rotated_expected.size() == 0);
                repeat (3) @(negedge clk);
                hold_off = 0;
            end
        end
        wait (rotated_expected.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        $display("sent %0d items, checked %0d rotated vectors", accepted, checked);
        $display("angles across full turn, unit/diagonal/odd axes, saturation");
        if (errors == 0)
            $display("[axis_angle_vector_rotate] OK");
        else
            $display("[axis_angle_vector_rotate] ERROR");
        $finish;
    end

endmodule
